[hw/rtl/dxt_pkg.sv]
// ----------------------------------------------------------------------------
// DXT block decoder package
// Format codes, queue entry type and constant-divide helpers.
// ----------------------------------------------------------------------------
package dxt_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // One decoded block waiting for pixel output.
  typedef struct packed {
    logic [1:0]             fmt;
    logic                   trans3;  // DXT1 three-colour mode: entry 3 is transparent
    logic [3:0][2:0][7:0]   cpal;    // [entry][0=red,1=green,2=blue]
    logic [7:0][7:0]        apal;
    logic [31:0]            cidx;
    logic [63:0]            ahalf;
  } dxt_entry_t;

  // x / 3, exact for x < 768
  function automatic logic [7:0] div3(input logic [10:0] x);
    logic [20:0] p;
    p = {10'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  // x / 5, exact for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

  // x / 7, exact for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

endpackage

[hw/rtl/dxt_in_if.sv]
// ----------------------------------------------------------------------------
// DXT block input channel
// Valid/ready channel carrying one compressed 4x4 block.
// ----------------------------------------------------------------------------
interface dxt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] first_half;
  logic [63:0] second_half;

  modport source (output valid, output first_half, output second_half, input ready);
  modport sink   (input valid, input first_half, input second_half, output ready);
endinterface

[hw/rtl/dxt_out_if.sv]
// ----------------------------------------------------------------------------
// DXT pixel output channel
// Valid/ready channel carrying one decoded pixel.
// ----------------------------------------------------------------------------
interface dxt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output alpha, output last, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input alpha, input last, output ready);
endinterface

[hw/rtl/dxt_block_decoder.sv]
// Path: a block passes the front register, the block queue and the output register
//   on its way to the first pixel; pixels follow one per cycle while pix_o.ready is high.
// Throughput: one pixel per cycle when the output does not stall, set by the output register.
// Input accepts while the block queue has room, so blocks overlap output.
// Reset: async active low; clears pipe, queue and counters, format to DXT1.
// ----------------------------------------------------------------------------
// DXT block decoder
// S3TC DXT1/DXT3/DXT5 4x4 block decompression to raster-order pixels.
// ----------------------------------------------------------------------------
module dxt_block_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  dxt_in_if.sink     blk_i,
  dxt_out_if.source  pix_o
);
  import dxt_pkg::*;

  logic [1:0] fmt_q;
  logic       push, full, q_valid, pop;
  dxt_entry_t entry, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_DXT1;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  dxt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fmt_i   (fmt_q),
    .blk_i   (blk_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  dxt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  dxt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .pix_o   (pix_o)
  );

`ifndef SYNTHESIS
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && pix_o.last |-> pix_o.pixel_index == 4'hF)
    else $error("last flag on a pixel other than fifteen");

  a_pix_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && pix_o.ready && !pix_o.last |=>
      !pix_o.valid || pix_o.pixel_index == $past(pix_o.pixel_index) + 4'd1)
    else $error("pixel index out of sequence");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> pix_o.valid && pix_o.last)
    else $error("queue pop without final pixel");
`endif

endmodule

[hw/rtl/dxt_front.sv]
// ----------------------------------------------------------------------------
// DXT front end
// Accepts a block, builds colour and alpha palettes, pushes them to the queue.
// ----------------------------------------------------------------------------
module dxt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          fmt_i,
  dxt_in_if.sink              blk_i,
  input  logic                full_i,
  output logic                push_o,
  output dxt_pkg::dxt_entry_t entry_o
);
  import dxt_pkg::*;

  logic        valid_q, valid_d;
  logic [63:0] first_q, second_q;
  logic [1:0]  fmt_q;
  logic        accept;

  logic [63:0] chalf;
  logic [15:0] c0, c1;
  logic        four;
  logic [2:0][7:0] e0, e1;
  logic [10:0] n2, n3;
  logic [8:0]  mid;
  logic [7:0]  a0, a1;
  logic [10:0] n5, n7;

  assign blk_i.ready = !valid_q || !full_i;
  assign accept      = blk_i.valid && blk_i.ready;
  assign push_o      = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q  <= blk_i.first_half;
      second_q <= blk_i.second_half;
      fmt_q    <= fmt_i;
    end
  end

  // Colour palette, then alpha palette (DXT5)
  always_comb begin
    chalf = (fmt_q == FMT_DXT1) ? first_q : second_q;
    c0    = chalf[15:0];
    c1    = chalf[31:16];
    four  = (fmt_q != FMT_DXT1) || (c0 > c1);
    e0[0] = {c0[15:11], 3'b000};
    e0[1] = {c0[10:5], 2'b00};
    e0[2] = {c0[4:0], 3'b000};
    e1[0] = {c1[15:11], 3'b000};
    e1[1] = {c1[10:5], 2'b00};
    e1[2] = {c1[4:0], 3'b000};
    entry_o.fmt    = fmt_q;
    entry_o.trans3 = !four;
    entry_o.cidx   = chalf[63:32];
    entry_o.ahalf  = first_q;
    for (int ch = 0; ch < 3; ch++) begin
      n2  = {2'b00, e0[ch], 1'b0} + {3'b000, e1[ch]};
      n3  = {3'b000, e0[ch]} + {2'b00, e1[ch], 1'b0};
      mid = {1'b0, e0[ch]} + {1'b0, e1[ch]};
      entry_o.cpal[0][ch] = e0[ch];
      entry_o.cpal[1][ch] = e1[ch];
      entry_o.cpal[2][ch] = four ? div3(n2) : mid[8:1];
      entry_o.cpal[3][ch] = four ? div3(n3) : 8'd0;
    end

    a0 = first_q[7:0];
    a1 = first_q[15:8];
    entry_o.apal[0] = a0;
    entry_o.apal[1] = a1;
    for (int k = 1; k <= 6; k++) begin
      n7 = 11'(7 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1};
      n5 = 11'(5 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1};
      if (a0 > a1) begin
        entry_o.apal[k + 1] = div7(n7);
      end else if (k <= 4) begin
        entry_o.apal[k + 1] = div5(n5);
      end else if (k == 5) begin
        entry_o.apal[k + 1] = 8'd0;
      end else begin
        entry_o.apal[k + 1] = 8'd255;
      end
    end
  end

endmodule

[hw/rtl/dxt_queue.sv]
// ----------------------------------------------------------------------------
// DXT block queue
// Small FIFO of decoded palettes between the front and back ends.
// ----------------------------------------------------------------------------
module dxt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dxt_pkg::dxt_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output dxt_pkg::dxt_entry_t head_o
);
  import dxt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dxt_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[hw/rtl/dxt_back.sv]
// ----------------------------------------------------------------------------
// DXT back end
// Walks the sixteen pixels of the head block into the output register.
// ----------------------------------------------------------------------------
module dxt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  dxt_pkg::dxt_entry_t head_i,
  output logic                pop_o,
  dxt_out_if.source           pix_o
);
  import dxt_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [3:0] cnt_q, cnt_d;
  logic       load;

  logic [3:0] pix_q;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic       last_q;

  logic [1:0] ci;
  logic [3:0] nib;
  logic [5:0] abit;
  logic [2:0] ai;
  logic [7:0] alpha;

  assign load  = valid_i && (!out_valid_q || pix_o.ready);
  assign pop_o = load && (cnt_q == 4'hF);

  always_comb begin
    ci   = head_i.cidx[{cnt_q, 1'b0} +: 2];
    nib  = head_i.ahalf[{cnt_q, 2'b00} +: 4];
    abit = {2'b00, cnt_q} + {1'b0, cnt_q, 1'b0} + 6'd16;
    ai   = head_i.ahalf[abit +: 3];
    if (head_i.fmt == FMT_DXT1) begin
      alpha = (head_i.trans3 && (ci == 2'd3)) ? 8'd0 : 8'd255;
    end else if (head_i.fmt == FMT_DXT3) begin
      alpha = {nib, nib};
    end else begin
      alpha = head_i.apal[ai];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    if (load) begin
      out_valid_d = 1'b1;
      cnt_d       = cnt_q + 4'd1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q   <= cnt_q;
      red_q   <= head_i.cpal[ci][0];
      green_q <= head_i.cpal[ci][1];
      blue_q  <= head_i.cpal[ci][2];
      alpha_q <= alpha;
      last_q  <= (cnt_q == 4'hF);
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_index = pix_q;
  assign pix_o.red         = red_q;
  assign pix_o.green       = green_q;
  assign pix_o.blue        = blue_q;
  assign pix_o.alpha       = alpha_q;
  assign pix_o.last        = last_q;

endmodule
